>>> rtl/cfpu_pkg.sv
`default_nettype none
package cfpu_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_W      = 6;

  localparam logic [CFG_IDX_W-1:0] REG_UP_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UP_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UP_Z = 2'd2;

  localparam logic [2:0] ACT_PLACE  = 3'd0;
  localparam logic [2:0] ACT_MOVE   = 3'd1;
  localparam logic [2:0] ACT_ROTATE = 3'd2;
  localparam logic [2:0] ACT_SETPOS = 3'd3;
  localparam logic [2:0] ACT_SETFR  = 3'd4;

  localparam logic [1:0] DIR_FWD   = 2'd0;
  localparam logic [1:0] DIR_BACK  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic [4:0] OP_NONE      = 5'd0;
  localparam logic [4:0] OP_PLACE     = 5'd1;
  localparam logic [4:0] OP_SETPOS    = 5'd2;
  localparam logic [4:0] OP_SETFR     = 5'd3;
  localparam logic [4:0] OP_MOVE      = 5'd4;
  localparam logic [4:0] OP_TARGET    = 5'd5;
  localparam logic [4:0] OP_ANG_INIT  = 5'd6;
  localparam logic [4:0] OP_CRD_STEP  = 5'd7;
  localparam logic [4:0] OP_ANG_SAVE  = 5'd8;
  localparam logic [4:0] OP_DIR_MUL   = 5'd9;
  localparam logic [4:0] OP_CROSS     = 5'd10;
  localparam logic [4:0] OP_N_INIT    = 5'd11;
  localparam logic [4:0] OP_N_SHIFT   = 5'd12;
  localparam logic [4:0] OP_N_SQ      = 5'd13;
  localparam logic [4:0] OP_SQRT_INIT = 5'd14;
  localparam logic [4:0] OP_SQRT_STEP = 5'd15;
  localparam logic [4:0] OP_DIV_INIT  = 5'd16;
  localparam logic [4:0] OP_DIV_STEP  = 5'd17;
  localparam logic [4:0] OP_DIV_SAVE  = 5'd18;
  localparam logic [4:0] OP_N_ZERO    = 5'd19;
  localparam logic [4:0] OP_EMIT      = 5'd20;

  localparam logic signed [15:0] PITCH_LIM = 16'sd5696;
  localparam logic signed [16:0] DEG720    = 17'sd46080;
  localparam logic signed [16:0] DEG360    = 17'sd23040;
  localparam logic signed [16:0] DEG180    = 17'sd11520;
  localparam logic signed [16:0] DEG90     = 17'sd5760;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  typedef struct packed {
    logic       rdy;
    logic [4:0] op;
    logic [1:0] sel;
    logic       dst;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [2:0] action;
    logic       zero;
    logic       in_range;
    logic       out_busy;
  } sts_t;

  // Arctangent of 2^-i in degrees with 16 fraction bits.
  function automatic logic [21:0] atan_deg16(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/cfpu_if.sv
`default_nettype none
interface cfpu_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [1:0]         move_dir;
  logic [15:0]        speed;
  logic signed [15:0] pitch_deg;
  logic signed [15:0] yaw_deg;
  logic signed [31:0] vec_a_x;
  logic signed [31:0] vec_a_y;
  logic signed [31:0] vec_a_z;
  logic signed [31:0] vec_b_x;
  logic signed [31:0] vec_b_y;
  logic signed [31:0] vec_b_z;

  modport source (output valid, action, move_dir, speed, pitch_deg, yaw_deg,
                  vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z,
                  input ready);
  modport sink (input valid, action, move_dir, speed, pitch_deg, yaw_deg,
                vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z,
                output ready);
endinterface

interface cfpu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] front_x;
  logic signed [15:0] front_y;
  logic signed [15:0] front_z;
  logic signed [31:0] tgt_x;
  logic signed [31:0] tgt_y;
  logic signed [31:0] tgt_z;

  modport source (output valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                  tgt_x, tgt_y, tgt_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                tgt_x, tgt_y, tgt_z, output ready);
endinterface
`default_nettype wire

>>> rtl/cfpu_ctrl.sv
`default_nettype none
module cfpu_ctrl import cfpu_pkg::*; #(
  parameter int TRIG_STEPS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_PLACE  = 5'd2;
  localparam logic [4:0] S_SETPOS = 5'd3;
  localparam logic [4:0] S_SETFR  = 5'd4;
  localparam logic [4:0] S_MOVE   = 5'd5;
  localparam logic [4:0] S_TGT    = 5'd6;
  localparam logic [4:0] S_AINIT  = 5'd7;
  localparam logic [4:0] S_CSTEP  = 5'd8;
  localparam logic [4:0] S_ASAVE  = 5'd9;
  localparam logic [4:0] S_DMUL   = 5'd10;
  localparam logic [4:0] S_CROSS  = 5'd11;
  localparam logic [4:0] S_NINIT  = 5'd12;
  localparam logic [4:0] S_NCHK   = 5'd13;
  localparam logic [4:0] S_NSHIFT = 5'd14;
  localparam logic [4:0] S_NSQ    = 5'd15;
  localparam logic [4:0] S_SINIT  = 5'd16;
  localparam logic [4:0] S_SSTEP  = 5'd17;
  localparam logic [4:0] S_DINIT  = 5'd18;
  localparam logic [4:0] S_DSTEP  = 5'd19;
  localparam logic [4:0] S_DSAVE  = 5'd20;
  localparam logic [4:0] S_OUT    = 5'd21;

  localparam logic [CNT_W-1:0] CRD_LAST  = CNT_W'(TRIG_STEPS - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(31);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(16);

  logic [4:0]       st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       sel_r, sel_nxt;
  logic             ang_r, ang_nxt;
  logic             dst_r, dst_nxt;
  logic [4:0]       ret_st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
      sel_r <= '0;
      ang_r <= 1'b0;
      dst_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      sel_r <= sel_nxt;
      ang_r <= ang_nxt;
      dst_r <= dst_nxt;
    end
  end

  // Where a finished normalisation hands back to.
  always_comb begin
    if (dst_r) begin
      ret_st = S_OUT;
    end else if (sts.action == ACT_ROTATE) begin
      ret_st = S_TGT;
    end else begin
      ret_st = S_CROSS;
    end
  end

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    sel_nxt = sel_r;
    ang_nxt = ang_r;
    dst_nxt = dst_r;
    cmd     = '0;
    cmd.sel = sel_r;
    cmd.dst = dst_r;
    cmd.idx = cnt_r[4:0];
    case (st_r)
      S_IDLE: begin
        cmd.rdy = 1'b1;
        if (sts.in_valid) begin
          st_nxt = S_DISP;
        end
      end
      S_DISP: begin
        sel_nxt = '0;
        ang_nxt = 1'b0;
        case (sts.action)
          ACT_PLACE:  st_nxt = S_PLACE;
          ACT_MOVE:   st_nxt = S_MOVE;
          ACT_ROTATE: st_nxt = S_AINIT;
          ACT_SETPOS: st_nxt = S_SETPOS;
          ACT_SETFR:  st_nxt = S_SETFR;
          default:    st_nxt = S_OUT;
        endcase
      end
      S_PLACE: begin
        cmd.op  = OP_PLACE;
        dst_nxt = 1'b0;
        st_nxt  = S_NINIT;
      end
      S_SETPOS: begin
        cmd.op = OP_SETPOS;
        st_nxt = S_OUT;
      end
      S_SETFR: begin
        cmd.op = OP_SETFR;
        st_nxt = S_OUT;
      end
      S_MOVE: begin
        cmd.op = OP_MOVE;
        if (sel_r == 2'd2) begin
          st_nxt = S_TGT;
        end else begin
          sel_nxt = sel_r + 2'd1;
        end
      end
      S_TGT: begin
        cmd.op = OP_TARGET;
        sel_nxt = '0;
        st_nxt = (sts.action == ACT_ROTATE) ? S_CROSS : S_OUT;
      end
      S_AINIT: begin
        cmd.op  = OP_ANG_INIT;
        cmd.sel = {1'b0, ang_r};
        cnt_nxt = '0;
        st_nxt  = S_CSTEP;
      end
      S_CSTEP: begin
        cmd.op = OP_CRD_STEP;
        if (cnt_r == CRD_LAST) begin
          st_nxt = S_ASAVE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ASAVE: begin
        cmd.op  = OP_ANG_SAVE;
        cmd.sel = {1'b0, ang_r};
        if (!ang_r) begin
          ang_nxt = 1'b1;
          st_nxt  = S_AINIT;
        end else begin
          sel_nxt = '0;
          st_nxt  = S_DMUL;
        end
      end
      S_DMUL: begin
        cmd.op = OP_DIR_MUL;
        if (sel_r == 2'd2) begin
          dst_nxt = 1'b0;
          st_nxt  = S_NINIT;
        end else begin
          sel_nxt = sel_r + 2'd1;
        end
      end
      S_CROSS: begin
        cmd.op = OP_CROSS;
        if (sel_r == 2'd2) begin
          dst_nxt = 1'b1;
          st_nxt  = S_NINIT;
        end else begin
          sel_nxt = sel_r + 2'd1;
        end
      end
      S_NINIT: begin
        cmd.op = OP_N_INIT;
        st_nxt = S_NCHK;
      end
      S_NCHK: begin
        sel_nxt = '0;
        if (sts.zero) begin
          cmd.op = OP_N_ZERO;
          st_nxt = ret_st;
        end else begin
          st_nxt = S_NSHIFT;
        end
      end
      S_NSHIFT: begin
        if (sts.in_range) begin
          st_nxt = S_NSQ;
        end else begin
          cmd.op = OP_N_SHIFT;
        end
      end
      S_NSQ: begin
        cmd.op = OP_N_SQ;
        if (sel_r == 2'd2) begin
          st_nxt = S_SINIT;
        end else begin
          sel_nxt = sel_r + 2'd1;
        end
      end
      S_SINIT: begin
        cmd.op  = OP_SQRT_INIT;
        cnt_nxt = '0;
        sel_nxt = '0;
        st_nxt  = S_SSTEP;
      end
      S_SSTEP: begin
        cmd.op = OP_SQRT_STEP;
        if (cnt_r == SQRT_LAST) begin
          st_nxt = S_DINIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DINIT: begin
        cmd.op  = OP_DIV_INIT;
        cnt_nxt = '0;
        st_nxt  = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op = OP_DIV_STEP;
        if (cnt_r == DIV_LAST) begin
          st_nxt = S_DSAVE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DSAVE: begin
        cmd.op = OP_DIV_SAVE;
        if (sel_r == 2'd2) begin
          sel_nxt = '0;
          st_nxt  = ret_st;
        end else begin
          sel_nxt = sel_r + 2'd1;
          st_nxt  = S_DINIT;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.op = OP_EMIT;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/cfpu_dp.sv
`default_nettype none
module cfpu_dp import cfpu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  cfpu_in_if.sink               in_item,
  cfpu_out_if.source            out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Pose and configuration.
  logic signed [15:0] up_r    [3];
  logic [31:0]        pos_r   [3];
  logic [31:0]        tgt_r   [3];
  logic signed [15:0] front_r [3];
  logic signed [15:0] right_r [3];
  logic               ov_r;

  // Captured item.
  logic [2:0]         act_r;
  logic [1:0]         dir_r;
  logic [15:0]        spd_r;
  logic signed [15:0] pitch_r, yaw_r;
  logic signed [31:0] a_r [3];
  logic signed [31:0] b_r [3];

  // Normalisation scratch.
  logic signed [63:0] nvec_r [3];
  logic [63:0]        mag_r  [3];
  logic [2:0]         neg_r;
  logic [61:0]        sum_r;
  logic [61:0]        sqn_r;
  logic [62:0]        sqr_r, sqb_r;
  logic [46:0]        rem_r;
  logic [47:0]        dsh_r;
  logic [16:0]        q_r;

  // Rotation scratch.
  logic signed [33:0] cx_r, cy_r;
  logic signed [25:0] cz_r;
  logic               cneg_r;
  logic signed [31:0] yc_r, ys_r, pc_r, ps_r;

  logic [31:0]        o_pos_r [3];
  logic [31:0]        o_tgt_r [3];
  logic signed [15:0] o_front_r [3];

  logic [63:0] mx;
  logic        take;
  assign take = cmd.rdy && in_item.valid;

  always_comb begin
    mx = mag_r[0];
    if (mag_r[1] > mx) mx = mag_r[1];
    if (mag_r[2] > mx) mx = mag_r[2];
  end

  assign in_item.ready = cmd.rdy;
  assign sts.in_valid  = in_item.valid;
  assign sts.action    = act_r;
  assign sts.zero      = (mx == 64'd0);
  assign sts.in_range  = (mx[63:30] == 34'd0) && mx[29];
  assign sts.out_busy  = ov_r && !out_item.ready;

  assign out_item.valid   = ov_r;
  assign out_item.pos_x   = o_pos_r[0];
  assign out_item.pos_y   = o_pos_r[1];
  assign out_item.pos_z   = o_pos_r[2];
  assign out_item.tgt_x   = o_tgt_r[0];
  assign out_item.tgt_y   = o_tgt_r[1];
  assign out_item.tgt_z   = o_tgt_r[2];
  assign out_item.front_x = o_front_r[0];
  assign out_item.front_y = o_front_r[1];
  assign out_item.front_z = o_front_r[2];

  // Angle reduction into [-90, 90] degrees with a negate flag.
  logic signed [15:0] pclamp, asrc;
  logic signed [16:0] ang1, ang2, ang3;
  logic               afold;
  always_comb begin
    pclamp = pitch_r;
    if (pitch_r > PITCH_LIM) pclamp = PITCH_LIM;
    if (pitch_r < -PITCH_LIM) pclamp = -PITCH_LIM;
    asrc = cmd.sel[0] ? pclamp : yaw_r;
    ang1 = {asrc[15], asrc};
    if (ang1 >= DEG360) begin
      ang2 = ang1 - DEG360;
    end else if (ang1 < -DEG360) begin
      ang2 = ang1 + DEG720;
    end else if (ang1 < 17'sd0) begin
      ang2 = ang1 + DEG360;
    end else begin
      ang2 = ang1;
    end
    if (ang2 > DEG180) ang2 = ang2 - DEG360;
    afold = 1'b0;
    ang3  = ang2;
    if (ang2 > DEG90) begin
      ang3  = ang2 - DEG180;
      afold = 1'b1;
    end else if (ang2 < -DEG90) begin
      ang3  = ang2 + DEG180;
      afold = 1'b1;
    end
  end

  // One rotation step of the shared CORDIC unit.
  logic signed [33:0] xsh, ysh, cx_nxt, cy_nxt;
  logic signed [25:0] at, cz_nxt;
  always_comb begin
    xsh = cx_r >>> cmd.idx;
    ysh = cy_r >>> cmd.idx;
    at  = $signed({4'b0, atan_deg16(cmd.idx)});
    if (!cz_r[25]) begin
      cx_nxt = cx_r - ysh;
      cy_nxt = cy_r + xsh;
      cz_nxt = cz_r - at;
    end else begin
      cx_nxt = cx_r + ysh;
      cy_nxt = cy_r - xsh;
      cz_nxt = cz_r + at;
    end
  end

  // Direction product and cross product for the selected component.
  logic signed [63:0] dmul;
  logic signed [15:0] fa, fb, ua, ub;
  logic signed [31:0] pa, pb;
  logic signed [63:0] crs;
  always_comb begin
    dmul = (cmd.sel == 2'd2 ? ys_r : yc_r) * pc_r;
    case (cmd.sel)
      2'd0: begin
        fa = front_r[1]; ub = up_r[2]; fb = front_r[2]; ua = up_r[1];
      end
      2'd1: begin
        fa = front_r[2]; ub = up_r[0]; fb = front_r[0]; ua = up_r[2];
      end
      default: begin
        fa = front_r[0]; ub = up_r[1]; fb = front_r[1]; ua = up_r[0];
      end
    endcase
    pa  = fa * ub;
    pb  = fb * ua;
    crs = 64'(pa) - 64'(pb);
  end

  // Move step for the selected component, rounded half away from zero.
  logic signed [15:0] mv;
  logic signed [32:0] mprod;
  logic [32:0]        mmag;
  logic [33:0]        mrnd;
  logic [31:0]        mstep;
  logic               msub;
  always_comb begin
    mv    = (dir_r == DIR_FWD || dir_r == DIR_BACK) ? front_r[cmd.sel] : right_r[cmd.sel];
    mprod = $signed({1'b0, spd_r}) * mv;
    mmag  = mprod[32] ? 33'(-mprod) : 33'(mprod);
    mrnd  = {1'b0, mmag} + 34'd32;
    mstep = {4'b0, mrnd[33:6]};
    msub  = (dir_r == DIR_BACK || dir_r == DIR_LEFT) ^ mprod[32];
  end

  // Square root step and divider step.
  logic [62:0] sqt;
  logic [59:0] sq;
  logic [15:0] qres;
  always_comb begin
    sqt  = sqr_r + sqb_r;
    sq   = mag_r[cmd.sel][29:0] * mag_r[cmd.sel][29:0];
    qres = neg_r[cmd.sel] ? 16'(-q_r[15:0]) : q_r[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r[0]    <= 16'sd0;
      up_r[1]    <= 16'sd16384;
      up_r[2]    <= 16'sd0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= 32'd0;
        tgt_r[i] <= 32'd0;
      end
      tgt_r[2]   <= 32'hFFFF_0000;
      front_r[0] <= 16'sd0;
      front_r[1] <= 16'sd0;
      front_r[2] <= -16'sd16384;
      right_r[0] <= 16'sd16384;
      right_r[1] <= 16'sd0;
      right_r[2] <= 16'sd0;
      ov_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_UP_X: up_r[0] <= cfg_wdata;
          REG_UP_Y: up_r[1] <= cfg_wdata;
          REG_UP_Z: up_r[2] <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_item.ready && cmd.op != OP_EMIT) ov_r <= 1'b0;
      case (cmd.op)
        OP_PLACE: begin
          for (int i = 0; i < 3; i++) begin
            pos_r[i] <= a_r[i];
            tgt_r[i] <= b_r[i];
          end
        end
        OP_SETPOS: begin
          for (int i = 0; i < 3; i++) pos_r[i] <= a_r[i];
        end
        OP_SETFR: begin
          for (int i = 0; i < 3; i++) begin
            if ((a_r[i] >>> 2) > 32'sd32767) begin
              front_r[i] <= 16'sd32767;
            end else if ((a_r[i] >>> 2) < -32'sd32768) begin
              front_r[i] <= -16'sd32768;
            end else begin
              front_r[i] <= a_r[i][17:2];
            end
          end
        end
        OP_MOVE: begin
          pos_r[cmd.sel] <= msub ? pos_r[cmd.sel] - mstep : pos_r[cmd.sel] + mstep;
        end
        OP_TARGET: begin
          for (int i = 0; i < 3; i++) begin
            tgt_r[i] <= pos_r[i] + {{14{front_r[i][15]}}, front_r[i], 2'b00};
          end
        end
        OP_DIV_SAVE: begin
          if (cmd.dst) right_r[cmd.sel] <= qres;
          else         front_r[cmd.sel] <= qres;
        end
        OP_N_ZERO: begin
          for (int i = 0; i < 3; i++) begin
            if (cmd.dst) right_r[i] <= 16'sd0;
            else         front_r[i] <= 16'sd0;
          end
        end
        OP_EMIT: begin
          ov_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      act_r   <= in_item.action;
      dir_r   <= in_item.move_dir;
      spd_r   <= in_item.speed;
      pitch_r <= in_item.pitch_deg;
      yaw_r   <= in_item.yaw_deg;
      a_r[0]  <= in_item.vec_a_x;
      a_r[1]  <= in_item.vec_a_y;
      a_r[2]  <= in_item.vec_a_z;
      b_r[0]  <= in_item.vec_b_x;
      b_r[1]  <= in_item.vec_b_y;
      b_r[2]  <= in_item.vec_b_z;
    end
    case (cmd.op)
      OP_PLACE: begin
        for (int i = 0; i < 3; i++) nvec_r[i] <= 64'(b_r[i]) - 64'(a_r[i]);
      end
      OP_ANG_INIT: begin
        cx_r   <= CORDIC_X0;
        cy_r   <= '0;
        cz_r   <= {ang3[15:0], 10'b0};
        cneg_r <= afold;
      end
      OP_CRD_STEP: begin
        cx_r <= cx_nxt;
        cy_r <= cy_nxt;
        cz_r <= cz_nxt;
      end
      OP_ANG_SAVE: begin
        if (cmd.sel[0]) begin
          pc_r <= cneg_r ? 32'(-cx_r) : cx_r[31:0];
          ps_r <= cneg_r ? 32'(-cy_r) : cy_r[31:0];
        end else begin
          yc_r <= cneg_r ? 32'(-cx_r) : cx_r[31:0];
          ys_r <= cneg_r ? 32'(-cy_r) : cy_r[31:0];
        end
      end
      OP_DIR_MUL: begin
        if (cmd.sel == 2'd1) nvec_r[1] <= {{2{ps_r[31]}}, ps_r, 30'b0};
        else                 nvec_r[cmd.sel] <= dmul;
      end
      OP_CROSS: begin
        nvec_r[cmd.sel] <= crs;
      end
      OP_N_INIT: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= nvec_r[i][63];
          mag_r[i] <= nvec_r[i][63] ? 64'(-nvec_r[i]) : 64'(nvec_r[i]);
        end
      end
      OP_N_SHIFT: begin
        for (int i = 0; i < 3; i++) begin
          if (mx[63:30] != 34'd0) mag_r[i] <= mag_r[i] >> 1;
          else                    mag_r[i] <= mag_r[i] << 1;
        end
      end
      OP_N_SQ: begin
        sum_r <= (cmd.sel == 2'd0 ? 62'd0 : sum_r) + {2'b0, sq};
      end
      OP_SQRT_INIT: begin
        sqn_r <= sum_r;
        sqr_r <= '0;
        sqb_r <= {1'b1, 62'd0};
      end
      OP_SQRT_STEP: begin
        if ({1'b0, sqn_r} >= sqt) begin
          sqn_r <= sqn_r - sqt[61:0];
          sqr_r <= (sqr_r >> 1) + sqb_r;
        end else begin
          sqr_r <= sqr_r >> 1;
        end
        sqb_r <= sqb_r >> 2;
      end
      OP_DIV_INIT: begin
        rem_r <= {3'b0, mag_r[cmd.sel][29:0], 14'b0} + {16'b0, sqr_r[31:1]};
        dsh_r <= {sqr_r[31:0], 16'b0};
        q_r   <= '0;
      end
      OP_DIV_STEP: begin
        if ({1'b0, rem_r} >= dsh_r) begin
          rem_r <= rem_r - dsh_r[46:0];
          q_r   <= {q_r[15:0], 1'b1};
        end else begin
          q_r   <= {q_r[15:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
      end
      OP_EMIT: begin
        for (int i = 0; i < 3; i++) begin
          o_pos_r[i]   <= pos_r[i];
          o_tgt_r[i]   <= tgt_r[i];
          o_front_r[i] <= front_r[i];
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/fly_camera_pose_update.sv
`default_nettype none
// Fly-camera pose unit: holds position, front, right and target and applies one action per
// input beat (place, move, rotate, set position, set front), returning the new pose as one
// output beat. Items are processed one at a time; a finished pose waits in an output register
// while the next beat is taken. Each normalisation aligns the vector with one-bit shifts (up
// to about 31), then runs the one-bit-per-cycle square root (32 steps) and the restoring
// divider (17 steps per component); it is cut short when the vector has zero length. Place
// runs two normalisations, and rotate adds the two CORDIC runs and the direction products.
// Writes to the up vector through the cfg port must be made only while the unit is idle;
// the block itself does not enforce this.
module fly_camera_pose_update import cfpu_pkg::*; #(
  parameter int TRIG_STEPS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  cfpu_in_if.sink               in_item,
  cfpu_out_if.source            out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  cfpu_ctrl #(
    .TRIG_STEPS(TRIG_STEPS)
  ) u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .sts  (sts),
    .cmd  (cmd)
  );

  cfpu_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_item  (in_item),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

endmodule
`default_nettype wire

>>> test/testbench.sv
`default_nettype none
module testbench import cfpu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TRIG_STEPS = 16;
  localparam int CYCLE_LIMIT = 2_500_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [2:0]         action;
    logic [1:0]         move_dir;
    logic [15:0]        speed;
    logic signed [15:0] pitch_deg;
    logic signed [15:0] yaw_deg;
    logic signed [31:0] ax, ay, az;
    logic signed [31:0] bx, by, bz;
  } cam_cmd_t;

  typedef struct {
    logic [31:0] px, py, pz;
    logic [15:0] fx, fy, fz;
    logic [31:0] tx, ty, tz;
  } pose_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cfpu_in_if  in_bus ();
  cfpu_out_if out_bus ();

  fly_camera_pose_update #(.TRIG_STEPS(TRIG_STEPS)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_item(in_bus), .out_item(out_bus),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Pose kept alongside the block.
  logic [31:0]        cam_pos [3];
  logic signed [15:0] cam_front [3];
  logic signed [15:0] cam_right [3];
  logic [31:0]        cam_tgt [3];
  logic signed [15:0] world_up [3];
  longint             atan_deg [32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  pose_t expected_poses [$];
  int    mismatches;
  int    idle_pct;
  int    stall_pct;
  longint cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void unit_vec(input longint vx, input longint vy, input longint vz,
                                   output logic signed [15:0] ox,
                                   output logic signed [15:0] oy,
                                   output logic signed [15:0] oz);
    longint v [3];
    longint unsigned m [3];
    bit neg [3];
    longint unsigned mx, sum, len, q;
    logic signed [15:0] r [3];
    v[0] = vx;
    v[1] = vy;
    v[2] = vz;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      m[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      ox = 0;
      oy = 0;
      oz = 0;
      return;
    end
    while (mx >= 64'd1 << 30) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < 64'd1 << 29) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      mx = mx << 1;
    end
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 16384 + len / 2) / len;
      r[i] = neg[i] ? -q[15:0] : q[15:0];
    end
    ox = r[0];
    oy = r[1];
    oz = r[2];
  endfunction

  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint x, y, z, nx;
    bit flip;
    x = CORDIC_X0;
    y = 0;
    flip = 0;
    ang = ang % DEG360;
    if (ang < 0) ang = ang + DEG360;
    if (ang > DEG180) ang = ang - DEG360;
    // Fold into the right half-plane; the results are negated afterwards.
    if (ang > DEG90) begin
      ang = ang - DEG180;
      flip = 1;
    end else if (ang < -DEG90) begin
      ang = ang + DEG180;
      flip = 1;
    end
    z = ang * 1024;
    for (int i = 0; i < TRIG_STEPS && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_deg[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_deg[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic void derive_right();
    longint fx, fy, fz, ux, uy, uz;
    fx = cam_front[0];
    fy = cam_front[1];
    fz = cam_front[2];
    ux = world_up[0];
    uy = world_up[1];
    uz = world_up[2];
    unit_vec(fy * uz - fz * uy, fz * ux - fx * uz, fx * uy - fy * ux,
             cam_right[0], cam_right[1], cam_right[2]);
  endfunction

  function automatic void derive_target();
    logic [31:0] f4;
    for (int i = 0; i < 3; i++) begin
      f4 = 32'(longint'(cam_front[i]) * 4);
      cam_tgt[i] = cam_pos[i] + f4;
    end
  endfunction

  function automatic longint round_q6(input longint v);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + 32) >>> 6;
    return v < 0 ? -m : m;
  endfunction

  function automatic pose_t apply_action(input cam_cmd_t c);
    longint a [3];
    longint b [3];
    longint cy, sy, cp, sp, st, f, pitch;
    logic signed [15:0] dirv [3];
    bit sub;
    pose_t p;
    a[0] = c.ax;
    a[1] = c.ay;
    a[2] = c.az;
    b[0] = c.bx;
    b[1] = c.by;
    b[2] = c.bz;
    case (c.action)
      ACT_PLACE: begin
        for (int i = 0; i < 3; i++) begin
          cam_pos[i] = a[i][31:0];
          cam_tgt[i] = b[i][31:0];
        end
        unit_vec(b[0] - a[0], b[1] - a[1], b[2] - a[2],
                 cam_front[0], cam_front[1], cam_front[2]);
        derive_right();
      end
      ACT_MOVE: begin
        for (int i = 0; i < 3; i++) begin
          dirv[i] = (c.move_dir == DIR_FWD || c.move_dir == DIR_BACK) ? cam_front[i]
                                                                      : cam_right[i];
        end
        sub = (c.move_dir == DIR_BACK || c.move_dir == DIR_LEFT);
        for (int i = 0; i < 3; i++) begin
          st = round_q6(longint'(c.speed) * longint'(dirv[i]));
          cam_pos[i] = sub ? cam_pos[i] - st[31:0] : cam_pos[i] + st[31:0];
        end
        derive_target();
      end
      ACT_ROTATE: begin
        pitch = c.pitch_deg;
        if (pitch > PITCH_LIM) pitch = PITCH_LIM;
        if (pitch < -PITCH_LIM) pitch = -PITCH_LIM;
        sin_cos(c.yaw_deg, cy, sy);
        sin_cos(pitch, cp, sp);
        unit_vec(cy * cp, sp * (64'sd1 <<< 30), sy * cp,
                 cam_front[0], cam_front[1], cam_front[2]);
        derive_target();
        derive_right();
      end
      ACT_SETPOS: begin
        for (int i = 0; i < 3; i++) cam_pos[i] = a[i][31:0];
      end
      ACT_SETFR: begin
        for (int i = 0; i < 3; i++) begin
          f = a[i] >>> 2;
          if (f > 32767) f = 32767;
          if (f < -32768) f = -32768;
          cam_front[i] = f[15:0];
        end
      end
      default: begin
      end
    endcase
    p.px = cam_pos[0];
    p.py = cam_pos[1];
    p.pz = cam_pos[2];
    p.fx = cam_front[0];
    p.fy = cam_front[1];
    p.fz = cam_front[2];
    p.tx = cam_tgt[0];
    p.ty = cam_tgt[1];
    p.tz = cam_tgt[2];
    return p;
  endfunction

  always @(posedge clk) begin
    pose_t e;
    pose_t g;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      g.px = out_bus.pos_x;
      g.py = out_bus.pos_y;
      g.pz = out_bus.pos_z;
      g.fx = out_bus.front_x;
      g.fy = out_bus.front_y;
      g.fz = out_bus.front_z;
      g.tx = out_bus.tgt_x;
      g.ty = out_bus.tgt_y;
      g.tz = out_bus.tgt_z;
      if (expected_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose beat: pos %h %h %h", g.px, g.py, g.pz);
      end else begin
        e = expected_poses.pop_front();
        if (g.px !== e.px || g.py !== e.py || g.pz !== e.pz ||
            g.fx !== e.fx || g.fy !== e.fy || g.fz !== e.fz ||
            g.tx !== e.tx || g.ty !== e.ty || g.tz !== e.tz) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("pose mismatch exp pos %h %h %h front %h %h %h tgt %h %h %h",
                     e.px, e.py, e.pz, e.fx, e.fy, e.fz, e.tx, e.ty, e.tz);
            $display("               got pos %h %h %h front %h %h %h tgt %h %h %h",
                     g.px, g.py, g.pz, g.fx, g.fy, g.fz, g.tx, g.ty, g.tz);
          end
        end
      end
    end
  end

  task automatic send_cmd(input cam_cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.action    <= c.action;
    in_bus.move_dir  <= c.move_dir;
    in_bus.speed     <= c.speed;
    in_bus.pitch_deg <= c.pitch_deg;
    in_bus.yaw_deg   <= c.yaw_deg;
    in_bus.vec_a_x   <= c.ax;
    in_bus.vec_a_y   <= c.ay;
    in_bus.vec_a_z   <= c.az;
    in_bus.vec_b_x   <= c.bx;
    in_bus.vec_b_y   <= c.by;
    in_bus.vec_b_z   <= c.bz;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    expected_poses.push_back(apply_action(c));
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_up(input logic signed [15:0] ux, input logic signed [15:0] uy,
                          input logic signed [15:0] uz);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_UP_X;
    cfg_wdata <= ux;
    @(posedge clk);
    cfg_idx   <= REG_UP_Y;
    cfg_wdata <= uy;
    @(posedge clk);
    cfg_idx   <= REG_UP_Z;
    cfg_wdata <= uz;
    @(posedge clk);
    // A write to the spare index must leave the up vector alone.
    cfg_idx   <= REG_UNUSED;
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
    world_up[0] = ux;
    world_up[1] = uy;
    world_up[2] = uz;
    @(posedge clk);
  endtask

  function automatic cam_cmd_t blank_cmd(input logic [2:0] act);
    cam_cmd_t c;
    c.action    = act;
    c.move_dir  = DIR_FWD;
    c.speed     = 16'h0100;
    c.pitch_deg = 0;
    c.yaw_deg   = 0;
    c.ax = 0;
    c.ay = 0;
    c.az = 0;
    c.bx = 0;
    c.by = 0;
    c.bz = 0;
    return c;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    int r;
    r = $urandom_range(9);
    if (r < 5) return $signed(32'($urandom_range(2097152))) - 32'sd1048576;
    if (r == 5) return 32'sh7fff_ffff;
    if (r == 6) return 32'sh8000_0000;
    return 32'($urandom);
  endfunction

  function automatic cam_cmd_t rand_cmd();
    cam_cmd_t c;
    int r;
    c.move_dir  = 2'($urandom);
    c.speed     = 16'($urandom);
    c.pitch_deg = 16'($urandom);
    c.yaw_deg   = 16'($urandom);
    c.ax = rand_coord();
    c.ay = rand_coord();
    c.az = rand_coord();
    c.bx = rand_coord();
    c.by = rand_coord();
    c.bz = rand_coord();
    r = $urandom_range(99);
    if (r < 30) begin
      c.action = ACT_MOVE;
    end else if (r < 50) begin
      c.action = ACT_ROTATE;
      if ($urandom_range(1)) c.pitch_deg = $signed(16'($urandom_range(12000))) - 16'sd6000;
    end else if (r < 65) begin
      c.action = ACT_PLACE;
      if ($urandom_range(9) == 0) begin
        c.bx = c.ax;
        c.by = c.ay;
        c.bz = c.az;
      end
    end else if (r < 75) begin
      c.action = ACT_SETPOS;
    end else if (r < 87) begin
      c.action = ACT_SETFR;
      if ($urandom_range(2) != 0) begin
        c.ax = $signed(32'($urandom_range(131072))) - 32'sd65536;
        c.ay = $signed(32'($urandom_range(131072))) - 32'sd65536;
        c.az = $signed(32'($urandom_range(131072))) - 32'sd65536;
      end
    end else begin
      c.action = 3'($urandom);
    end
    return c;
  endfunction

  function automatic logic signed [15:0] rand_up();
    return $signed(16'($urandom_range(32768))) - 16'sd16384;
  endfunction

  task automatic test_directed();
    cam_cmd_t c;
    c = blank_cmd(ACT_MOVE);
    for (int d = 0; d < 4; d++) begin
      c.move_dir = 2'(d);
      c.speed = (d % 2) ? 16'hffff : 16'h0000;
      send_cmd(c);
    end
    c = blank_cmd(ACT_SETPOS);
    c.ax = 32'sh7fff_ffff;
    c.ay = 32'sh8000_0000;
    c.az = -1;
    send_cmd(c);
    // Position wraps when stepped past the largest value.
    c = blank_cmd(ACT_MOVE);
    c.move_dir = DIR_RIGHT;
    c.speed = 16'hffff;
    send_cmd(c);
    c.move_dir = DIR_LEFT;
    send_cmd(c);
    c = blank_cmd(ACT_ROTATE);
    c.pitch_deg = 16'sh7fff;
    c.yaw_deg = 16'sh8000;
    send_cmd(c);
    c.pitch_deg = 16'sh8000;
    c.yaw_deg = 16'sh7fff;
    send_cmd(c);
    c.pitch_deg = 0;
    c.yaw_deg = 16'sd5760;
    send_cmd(c);
    c.yaw_deg = -16'sd11520;
    send_cmd(c);
    // Target equal to position: the front and right vectors collapse to zero.
    c = blank_cmd(ACT_PLACE);
    c.ax = 32'sd65536;
    c.bx = 32'sd65536;
    send_cmd(c);
    // Front straight up, parallel to the world up vector.
    c = blank_cmd(ACT_PLACE);
    c.by = 32'sd65536;
    send_cmd(c);
    c = blank_cmd(ACT_MOVE);
    c.move_dir = DIR_RIGHT;
    c.speed = 16'hffff;
    send_cmd(c);
    c = blank_cmd(ACT_PLACE);
    c.ax = 32'sh8000_0000;
    c.ay = 32'sh8000_0000;
    c.az = 32'sh8000_0000;
    c.bx = 32'sh7fff_ffff;
    c.by = 32'sh7fff_ffff;
    c.bz = 32'sh7fff_ffff;
    send_cmd(c);
    c = blank_cmd(ACT_SETFR);
    c.ax = 32'sh7fff_ffff;
    c.ay = 32'sh8000_0000;
    c.az = -32'sd5;
    send_cmd(c);
    c = blank_cmd(ACT_MOVE);
    c.speed = 16'hffff;
    send_cmd(c);
    c = blank_cmd(3'd5);
    send_cmd(c);
    c = blank_cmd(3'd7);
    send_cmd(c);
    drain();
  endtask

  task automatic test_up_vector();
    logic signed [15:0] ups [5][3];
    cam_cmd_t c;
    ups = '{'{16'sd16384, 16'sd0, 16'sd0}, '{16'sd0, -16'sd16384, 16'sd0},
            '{-16'sd16384, -16'sd16384, -16'sd16384}, '{16'sd16384, 16'sd16384, 16'sd16384},
            '{16'sd0, 16'sd0, -16'sd16384}};
    for (int k = 0; k < 5; k++) begin
      write_up(ups[k][0], ups[k][1], ups[k][2]);
      c = blank_cmd(ACT_ROTATE);
      c.yaw_deg = 16'($urandom);
      c.pitch_deg = 16'($urandom);
      send_cmd(c);
      c = blank_cmd(ACT_MOVE);
      c.move_dir = DIR_RIGHT;
      c.speed = 16'h0400;
      send_cmd(c);
      c = blank_cmd(ACT_PLACE);
      c.bx = 32'sd65536;
      c.bz = -32'sd131072;
      send_cmd(c);
      drain();
    end
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
    write_up(rand_up(), rand_up(), rand_up());
    for (int k = 0; k < n; k++) send_cmd(rand_cmd());
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_UP_X;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.action = ACT_PLACE;
    in_bus.move_dir = DIR_FWD;
    in_bus.speed = '0;
    in_bus.pitch_deg = '0;
    in_bus.yaw_deg = '0;
    in_bus.vec_a_x = '0;
    in_bus.vec_a_y = '0;
    in_bus.vec_a_z = '0;
    in_bus.vec_b_x = '0;
    in_bus.vec_b_y = '0;
    in_bus.vec_b_z = '0;
    out_bus.ready = 1'b0;
    cycles = 0;
    mismatches = 0;
    idle_pct = 0;
    stall_pct = 0;
    cam_pos = '{32'd0, 32'd0, 32'd0};
    cam_front = '{16'sd0, 16'sd0, -16'sd16384};
    cam_right = '{16'sd16384, 16'sd0, 16'sd0};
    cam_tgt = '{32'd0, 32'd0, -32'sd65536};
    world_up = '{16'sd0, 16'sd16384, 16'sd0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_up_vector();
    test_random(400, 0, 0);
    test_random(300, 79, 0);
    test_random(300, 0, 79);
    test_random(300, 14, 14);
    write_up(16'sd0, 16'sd16384, 16'sd0);
    test_random(50, 0, 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_poses.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
rtl/cfpu_pkg.sv
rtl/cfpu_if.sv
rtl/cfpu_ctrl.sv
rtl/cfpu_dp.sv
rtl/fly_camera_pose_update.sv
test/testbench.sv
